// ===== hw/rtl/rgbhsl_pkg.sv =====
// ----------------------------------------------------------------------------
// rgbhsl_pkg
// Shared constants and types for the RGB to HSL converter.
// ----------------------------------------------------------------------------
package rgbhsl_pkg;

  // Default channel width of the input pixel
  localparam int CHANNEL_BITS_DEF = 8;

  // Result field width (hue, saturation, lightness)
  localparam int OUT_W = 15;

  // Hue in 1/64 degree: one 60 degree sector and the full circle
  localparam int HUE_SECTOR = 3840;
  localparam int HUE_FULL   = 23040;

  // 100 percent in 1/256 percent
  localparam int PCT_FULL = 25600;

  // Which channel holds the maximum (red wins ties, then green)
  typedef enum logic [1:0] {
    SEC_RED   = 2'd0,
    SEC_GREEN = 2'd1,
    SEC_BLUE  = 2'd2
  } sector_t;

endpackage

// ===== hw/rtl/rgbhsl_if.sv =====
// ----------------------------------------------------------------------------
// rgbhsl_rgb_if / rgbhsl_hsl_if
// Valid/ready channels for the input pixel and the HSL result.
// ----------------------------------------------------------------------------
interface rgbhsl_rgb_if #(
  parameter int CHANNEL_BITS = rgbhsl_pkg::CHANNEL_BITS_DEF
);
  logic                    valid;
  logic                    ready;
  logic [CHANNEL_BITS-1:0] red;
  logic [CHANNEL_BITS-1:0] green;
  logic [CHANNEL_BITS-1:0] blue;

  modport source (output valid, output red, output green, output blue, input ready);
  modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

interface rgbhsl_hsl_if;
  logic                          valid;
  logic                          ready;
  logic [rgbhsl_pkg::OUT_W-1:0]  hue;
  logic [rgbhsl_pkg::OUT_W-1:0]  saturation;
  logic [rgbhsl_pkg::OUT_W-1:0]  lightness;

  modport source (output valid, output hue, output saturation, output lightness,
                  input ready);
  modport sink   (input valid, input hue, input saturation, input lightness,
                  output ready);
endinterface

// ===== hw/rtl/rgbhsl_div.sv =====
// ----------------------------------------------------------------------------
// rgbhsl_div
// Pipelined restoring divider, one quotient bit per stage, Q_W stages.
// The quotient must fit in Q_W bits.
// ----------------------------------------------------------------------------
module rgbhsl_div #(
  parameter int NUM_W = 25,
  parameter int DEN_W = 9,
  parameter int Q_W   = 15
) (
  input  logic             clk,
  input  logic             en,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic [Q_W-1:0]   quo_o
);

  localparam int CW = (NUM_W > DEN_W + Q_W) ? NUM_W : DEN_W + Q_W;

  logic [NUM_W-1:0] rem_r [Q_W];
  logic [DEN_W-1:0] den_r [Q_W];
  logic [Q_W-1:0]   quo_r [Q_W];

  for (genvar i = 0; i < Q_W; i++) begin : g_stage
    localparam int K = Q_W - 1 - i;

    logic [NUM_W-1:0] rem_in;
    logic [DEN_W-1:0] den_in;
    logic [Q_W-1:0]   quo_in;
    logic [CW-1:0]    trial;
    logic             take;
    logic [NUM_W-1:0] rem_nxt;
    logic [Q_W-1:0]   quo_nxt;

    if (i == 0) begin : g_first
      assign rem_in = num_i;
      assign den_in = den_i;
      assign quo_in = '0;
    end else begin : g_next
      assign rem_in = rem_r[i-1];
      assign den_in = den_r[i-1];
      assign quo_in = quo_r[i-1];
    end

    always_comb begin
      trial   = CW'(den_in) << K;
      take    = (CW'(rem_in) >= trial);
      rem_nxt = take ? NUM_W'(CW'(rem_in) - trial) : rem_in;
      quo_nxt = quo_in;
      quo_nxt[K] = take;
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[i] <= rem_nxt;
        den_r[i] <= den_in;
        quo_r[i] <= quo_nxt;
      end
    end
  end

  assign quo_o = quo_r[Q_W-1];

endmodule

// ===== hw/rtl/rgb_to_hsl_converter.sv =====
// ----------------------------------------------------------------------------
// rgb_to_hsl_converter
// Converts one RGB pixel per clock to hue, saturation and lightness.
// ----------------------------------------------------------------------------
//  Channel   Dir  Fields                          Handshake
//  in_ch     in   red, green, blue                valid/ready
//  out_ch    out  hue, saturation, lightness      valid/ready
//
//  Fully pipelined: one pixel per cycle while out_ch does not stall, through
//  input, max/min, operand, bit-per-stage divider and output registers.
//  rst_n is synchronous; it clears the valid bits only.
//  A stall on out_ch freezes the whole pipeline; in_ch.ready drops with it.
// ----------------------------------------------------------------------------
module rgb_to_hsl_converter #(
  parameter int CHANNEL_BITS = rgbhsl_pkg::CHANNEL_BITS_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  rgbhsl_rgb_if.sink      in_ch,
  rgbhsl_hsl_if.source    out_ch
);

  import rgbhsl_pkg::*;

  localparam int CB  = CHANNEL_BITS;
  localparam int SW  = CB + 1;   // hi + lo
  localparam int NW  = CB + 17;  // divider numerators
  localparam int DW  = CB + 1;   // divider denominators
  localparam int NST = OUT_W;    // divider stages

  localparam logic [CB-1:0] CMAX = {CB{1'b1}};

  // lightness = floor((sum * PCT_FULL + CMAX) / (2 * CMAX)) by reciprocal
  // multiply; the shift is wide enough to be exact for every sum
  localparam longint unsigned CMAX_L   = (64'd1 << CB) - 64'd1;
  localparam longint unsigned LIG_D    = 2 * CMAX_L;
  localparam longint unsigned LIG_NMAX = LIG_D * PCT_FULL + CMAX_L;
  localparam int              LIG_S    = $clog2(LIG_NMAX) + $clog2(LIG_D);
  localparam longint unsigned LIG_M    = ((64'd1 << LIG_S) + LIG_D - 64'd1) / LIG_D;
  localparam longint unsigned LIG_K1   = LIG_M * PCT_FULL;
  localparam longint unsigned LIG_K0   = LIG_M * CMAX_L;
  localparam int              LPW      = LIG_S + OUT_W;

  logic en;

  // ---- stage 1: input register
  logic          s1_valid_r;
  logic [CB-1:0] s1_red_r, s1_green_r, s1_blue_r;

  // ---- stage 2: max/min, sector
  logic          s2_valid_r;
  logic [CB-1:0] s2_delta_r, s2_pos_r, s2_neg_r;
  logic [SW-1:0] s2_sum_r;
  sector_t       s2_sec_r;
  logic          s2_grey_r;

  logic [CB-1:0] hi, lo, pos_nxt, neg_nxt;
  sector_t       sec_nxt;

  // ---- stage 3: numerators and denominators
  logic             s3_valid_r, s3_grey_r;
  logic [NW-1:0]    s3_hnum_r, s3_snum_r;
  logic [DW-1:0]    s3_hden_r, s3_sden_r;
  logic [OUT_W-1:0] s3_lig_r;

  logic [NW-1:0]    hbase, hacc, hneg, hadj, hnum, hue_num, sat_num;
  logic [CB-1:0]    span;
  logic [SW-1:0]    twice_max;
  logic [LPW-1:0]   lig_prod;
  logic [OUT_W-1:0] lig_val;

  // ---- divider stages
  logic             dv_valid_r [NST];
  logic             dv_grey_r  [NST];
  logic [OUT_W-1:0] dv_lig_r   [NST];
  logic [OUT_W-1:0] hue_q, sat_q;

  // ---- output register
  logic             out_valid_r;
  logic [OUT_W-1:0] out_hue_r, out_sat_r, out_lig_r;
  logic [OUT_W-1:0] hue_fix;

  assign en          = !out_valid_r || out_ch.ready;
  assign in_ch.ready = en;

  // stage 2 logic
  always_comb begin
    hi = s1_red_r;
    lo = s1_red_r;
    if (s1_green_r > hi) hi = s1_green_r;
    if (s1_blue_r  > hi) hi = s1_blue_r;
    if (s1_green_r < lo) lo = s1_green_r;
    if (s1_blue_r  < lo) lo = s1_blue_r;

    if (hi == s1_red_r) begin
      sec_nxt = SEC_RED;
      pos_nxt = s1_green_r;
      neg_nxt = s1_blue_r;
    end else if (hi == s1_green_r) begin
      sec_nxt = SEC_GREEN;
      pos_nxt = s1_blue_r;
      neg_nxt = s1_red_r;
    end else begin
      sec_nxt = SEC_BLUE;
      pos_nxt = s1_red_r;
      neg_nxt = s1_green_r;
    end
  end

  // stage 3 logic: operands for round(n/d) = (2n + d) / 2d
  always_comb begin
    case (s2_sec_r)
      SEC_RED:   hbase = '0;
      SEC_GREEN: hbase = NW'(s2_delta_r) * NW'(2 * HUE_SECTOR);
      SEC_BLUE:  hbase = NW'(s2_delta_r) * NW'(4 * HUE_SECTOR);
      default:   hbase = '0;
    endcase
    hacc = hbase + NW'(s2_pos_r) * NW'(HUE_SECTOR);
    hneg = NW'(s2_neg_r) * NW'(HUE_SECTOR);
    // wrap negative hue by a full circle
    hadj = (hacc < hneg) ? hacc + NW'(s2_delta_r) * NW'(HUE_FULL) : hacc;
    hnum = hadj - hneg;
    hue_num = (hnum << 1) + NW'(s2_delta_r);

    twice_max = {CMAX, 1'b0};
    span = (s2_sum_r <= SW'(CMAX)) ? CB'(s2_sum_r) : CB'(twice_max - s2_sum_r);
    sat_num = NW'(s2_delta_r) * NW'(2 * PCT_FULL) + NW'(span);

    lig_prod = LPW'(s2_sum_r) * LPW'(LIG_K1) + LPW'(LIG_K0);
    lig_val  = lig_prod[LIG_S +: OUT_W];
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      s3_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < NST; i++) dv_valid_r[i] <= 1'b0;
    end else if (en) begin
      s1_valid_r <= in_ch.valid;
      s2_valid_r <= s1_valid_r;
      s3_valid_r <= s2_valid_r;
      dv_valid_r[0] <= s3_valid_r;
      for (int i = 1; i < NST; i++) dv_valid_r[i] <= dv_valid_r[i-1];
      out_valid_r <= dv_valid_r[NST-1];
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (en) begin
      s1_red_r   <= in_ch.red;
      s1_green_r <= in_ch.green;
      s1_blue_r  <= in_ch.blue;

      s2_delta_r <= hi - lo;
      s2_sum_r   <= SW'(hi) + SW'(lo);
      s2_pos_r   <= pos_nxt;
      s2_neg_r   <= neg_nxt;
      s2_sec_r   <= sec_nxt;
      s2_grey_r  <= (hi == lo);

      s3_grey_r  <= s2_grey_r;
      s3_hnum_r  <= hue_num;
      s3_hden_r  <= {s2_delta_r, 1'b0};
      s3_snum_r  <= sat_num;
      s3_sden_r  <= {span, 1'b0};
      s3_lig_r   <= lig_val;

      dv_grey_r[0] <= s3_grey_r;
      dv_lig_r[0]  <= s3_lig_r;
      for (int i = 1; i < NST; i++) begin
        dv_grey_r[i] <= dv_grey_r[i-1];
        dv_lig_r[i]  <= dv_lig_r[i-1];
      end

      out_hue_r <= dv_grey_r[NST-1] ? '0 : hue_fix;
      out_sat_r <= dv_grey_r[NST-1] ? '0 : sat_q;
      out_lig_r <= dv_lig_r[NST-1];
    end
  end

  // hue that rounds up to a full circle wraps to zero
  assign hue_fix = (hue_q >= OUT_W'(HUE_FULL)) ? hue_q - OUT_W'(HUE_FULL) : hue_q;

  rgbhsl_div #(.NUM_W(NW), .DEN_W(DW), .Q_W(OUT_W)) u_div_hue (
    .clk   (clk),
    .en    (en),
    .num_i (s3_hnum_r),
    .den_i (s3_hden_r),
    .quo_o (hue_q)
  );

  // black and white pixels reach this with a zero divisor; grey results are discarded
  rgbhsl_div #(.NUM_W(NW), .DEN_W(DW), .Q_W(OUT_W)) u_div_sat (
    .clk   (clk),
    .en    (en),
    .num_i (s3_snum_r),
    .den_i (s3_sden_r),
    .quo_o (sat_q)
  );

  assign out_ch.valid      = out_valid_r;
  assign out_ch.hue        = out_hue_r;
  assign out_ch.saturation = out_sat_r;
  assign out_ch.lightness  = out_lig_r;

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Checks rgb_to_hsl_converter. Pixels are fed with random gaps on the input
// side and random stalls on the result side. Every accepted pixel is
// converted by a bit-exact integer predictor, and each result is compared
// in order, field by field.
// ----------------------------------------------------------------------------
module testbench;
  import rgbhsl_pkg::*;

  localparam int CB           = CHANNEL_BITS_DEF;
  localparam int LATENCY      = OUT_W + 4;
  localparam int RANDOM_ITEMS = 400;
  localparam int QUIET_LIMIT  = 2000;

  localparam longint unsigned CHAN_MAX = (64'd1 << CB) - 1;
  localparam logic [CB-1:0] FULL = '1;
  localparam logic [CB-1:0] HALF = FULL >> 1;

  typedef struct packed {
    logic [CB-1:0] red;
    logic [CB-1:0] green;
    logic [CB-1:0] blue;
  } pixel_t;

  typedef struct packed {
    logic [OUT_W-1:0] hue;
    logic [OUT_W-1:0] saturation;
    logic [OUT_W-1:0] lightness;
  } hsl_t;

  class hsl_scoreboard;
    hsl_t expected_hsl[$];
    int   errors;

    function new();
      errors = 0;
    endfunction

    // Nearest, halves up
    function longint unsigned round_half_up(longint unsigned num, longint unsigned den);
      if (den == 0) return 0;
      return (2 * num + den) / (2 * den);
    endfunction

    function hsl_t convert_pixel(pixel_t px);
      longint unsigned r, g, b, hi, lo, delta, sum, span;
      longint unsigned pos, neg, base, num, hue, sat, lig;
      sector_t sec;
      hsl_t res;
      r = px.red;
      g = px.green;
      b = px.blue;
      hi = r;
      lo = r;
      if (g > hi) hi = g;
      if (b > hi) hi = b;
      if (g < lo) lo = g;
      if (b < lo) lo = b;
      delta = hi - lo;
      sum = hi + lo;
      lig = round_half_up(sum * (PCT_FULL / 2), CHAN_MAX);
      if (delta == 0) begin
        hue = 0;
        sat = 0;
      end else begin
        sec = (hi == r) ? SEC_RED : (hi == g) ? SEC_GREEN : SEC_BLUE;
        case (sec)
          SEC_RED: begin
            pos = g; neg = b; base = 0;
          end
          SEC_GREEN: begin
            pos = b; neg = r; base = 2 * HUE_SECTOR;
          end
          default: begin
            pos = r; neg = g; base = 4 * HUE_SECTOR;
          end
        endcase
        // keep the numerator non-negative by adding a full turn
        num = base * delta + HUE_SECTOR * pos;
        if (num < HUE_SECTOR * neg) num += HUE_FULL * delta;
        num -= HUE_SECTOR * neg;
        hue = round_half_up(num, delta);
        if (hue >= HUE_FULL) hue -= HUE_FULL;
        span = (sum <= CHAN_MAX) ? sum : (2 * CHAN_MAX - sum);
        sat = round_half_up(delta * PCT_FULL, span);
      end
      res.hue        = OUT_W'(hue);
      res.saturation = OUT_W'(sat);
      res.lightness  = OUT_W'(lig);
      return res;
    endfunction

    task report_mismatch(string msg);
      $display("[%0t] MISMATCH: %s", $realtime, msg);
      errors++;
    endtask

    function void note_pixel(pixel_t px);
      expected_hsl.push_back(convert_pixel(px));
    endfunction

    task check_result(hsl_t got);
      hsl_t exp_hsl;
      string bad;
      if (expected_hsl.size() == 0) begin
        report_mismatch($sformatf("unexpected result h=%0d s=%0d l=%0d",
                                  got.hue, got.saturation, got.lightness));
        return;
      end
      exp_hsl = expected_hsl.pop_front();
      bad = "";
      if (got.hue !== exp_hsl.hue)
        bad = {bad, $sformatf(" hue %0d/%0d", got.hue, exp_hsl.hue)};
      if (got.saturation !== exp_hsl.saturation)
        bad = {bad, $sformatf(" saturation %0d/%0d", got.saturation, exp_hsl.saturation)};
      if (got.lightness !== exp_hsl.lightness)
        bad = {bad, $sformatf(" lightness %0d/%0d", got.lightness, exp_hsl.lightness)};
      if (bad != "") report_mismatch({"got/expected:", bad});
    endtask
  endclass

  logic clk;
  logic rst_n;
  bit   tx_idle = 1'b1;
  bit   rx_idle = 1'b1;
  int   quiet_cycles = 0;

  hsl_scoreboard sb = new();

  rgbhsl_rgb_if #(.CHANNEL_BITS(CB)) pix_if ();
  rgbhsl_hsl_if hsl_if ();

  rgb_to_hsl_converter #(.CHANNEL_BITS(CB)) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (pix_if),
    .out_ch (hsl_if)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  task send_pixel(input pixel_t px);
    int gap;
    gap = tx_idle ? $urandom_range(0, 7) : 0;
    if (gap > 0) begin
      pix_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pix_if.valid <= 1'b1;
    pix_if.red   <= px.red;
    pix_if.green <= px.green;
    pix_if.blue  <= px.blue;
    @(posedge clk);
    while (!pix_if.ready) @(posedge clk);
    sb.note_pixel(px);
    if ($urandom_range(0, 39) == 0) tx_idle = !tx_idle;
  endtask

  function automatic pixel_t random_pixel();
    pixel_t px;
    logic [CB-1:0] v, w;
    px.red   = CB'($urandom);
    px.green = CB'($urandom);
    px.blue  = CB'($urandom);
    case ($urandom_range(0, 9))
      0: begin
        // grey
        px.green = px.red;
        px.blue  = px.red;
      end
      1: begin
        // two channels tied at the maximum
        v = CB'($urandom);
        w = CB'($urandom_range(0, int'(v)));
        case ($urandom_range(0, 2))
          0: px = '{red: v, green: v, blue: w};
          1: px = '{red: w, green: v, blue: v};
          default: px = '{red: v, green: w, blue: v};
        endcase
      end
      2: begin
        // channels near the ends of the range
        px.red   = $urandom_range(0, 1) ? FULL - CB'($urandom_range(0, 1))
                                        : CB'($urandom_range(0, 1));
        px.green = $urandom_range(0, 1) ? FULL - CB'($urandom_range(0, 1))
                                        : CB'($urandom_range(0, 1));
        px.blue  = $urandom_range(0, 1) ? FULL - CB'($urandom_range(0, 1))
                                        : CB'($urandom_range(0, 1));
      end
      default: ;
    endcase
    return px;
  endfunction

  // result side: random stall before each transaction
  initial begin
    int stall;
    hsl_t got;
    hsl_if.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      stall = rx_idle ? $urandom_range(0, 7) : 0;
      if (stall > 0) begin
        hsl_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      hsl_if.ready <= 1'b1;
      @(posedge clk);
      while (!hsl_if.valid) @(posedge clk);
      got.hue        = hsl_if.hue;
      got.saturation = hsl_if.saturation;
      got.lightness  = hsl_if.lightness;
      sb.check_result(got);
      if ($urandom_range(0, 39) == 0) rx_idle = !rx_idle;
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (pix_if.valid && pix_if.ready) || (hsl_if.valid && hsl_if.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("testbench NOT OK");
      $finish;
    end
  end

  initial begin
    rst_n        <= 1'b0;
    pix_if.valid <= 1'b0;
    pix_if.red   <= '0;
    pix_if.green <= '0;
    pix_if.blue  <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // directed: greys, primaries, ties, wrap-around hues, lightness halves
    send_pixel('{red: 0,        green: 0,        blue: 0});
    send_pixel('{red: FULL,     green: FULL,     blue: FULL});
    send_pixel('{red: HALF,     green: HALF,     blue: HALF});
    send_pixel('{red: FULL,     green: 0,        blue: 0});
    send_pixel('{red: 0,        green: FULL,     blue: 0});
    send_pixel('{red: 0,        green: 0,        blue: FULL});
    send_pixel('{red: FULL,     green: FULL,     blue: 0});
    send_pixel('{red: 0,        green: FULL,     blue: FULL});
    send_pixel('{red: FULL,     green: 0,        blue: FULL});
    send_pixel('{red: FULL,     green: 0,        blue: 1});
    send_pixel('{red: FULL,     green: 1,        blue: 0});
    send_pixel('{red: 1,        green: 0,        blue: 0});
    send_pixel('{red: 0,        green: 0,        blue: 1});
    send_pixel('{red: 0,        green: 1,        blue: 1});
    send_pixel('{red: FULL,     green: FULL,     blue: FULL - CB'(1)});
    send_pixel('{red: FULL - CB'(1), green: FULL, blue: FULL});
    send_pixel('{red: FULL,     green: FULL - CB'(1), blue: FULL});
    send_pixel('{red: HALF + CB'(1), green: HALF, blue: HALF});
    send_pixel('{red: HALF,     green: HALF + CB'(1), blue: HALF + CB'(1)});
    send_pixel('{red: FULL,     green: HALF + CB'(1), blue: HALF});
    send_pixel('{red: 1,        green: FULL,     blue: 0});
    send_pixel('{red: FULL - CB'(1), green: 0,   blue: FULL});
    send_pixel('{red: 200,      green: 100,      blue: 150});

    repeat (RANDOM_ITEMS) send_pixel(random_pixel());
    pix_if.valid <= 1'b0;

    while (sb.expected_hsl.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    if (sb.errors == 0)
      $display("testbench OK");
    else
      $display("testbench NOT OK");
    $finish;
  end

endmodule
